// ===== src/owu_pkg.sv =====
// ----------------------------------------------------------------------------
// owu_pkg
// Shared types, codes and reset values of the optimizer weight update block.
// ----------------------------------------------------------------------------
`default_nettype none

package owu_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 24;
  localparam int CFG_IDX_W      = 3;
  localparam int MODE_W         = 3;

  // update rules; codes five to seven pass everything through
  typedef enum logic [MODE_W-1:0] {
    MODE_SGD      = 3'd0,
    MODE_MOMENTUM = 3'd1,
    MODE_ADAGRAD  = 3'd2,
    MODE_RMSPROP  = 3'd3,
    MODE_ADAM     = 3'd4
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE          = 3'd0,
    REG_LEARNING_RATE = 3'd1,
    REG_WEIGHT_DECAY  = 3'd2,
    REG_MOMENTUM_COEF = 3'd3,
    REG_SQUARE_COEF   = 3'd4,
    REG_EPSILON       = 3'd5
  } cfg_idx_e;

  // reset values, Q0.24 / Q8.24 units
  localparam logic [23:0] LEARNING_RATE_RST = 24'd16777;
  localparam logic [23:0] WEIGHT_DECAY_RST  = 24'd0;
  localparam logic [23:0] MOMENTUM_COEF_RST = 24'd15099494;
  localparam logic [23:0] SQUARE_COEF_RST   = 24'd16760439;
  localparam logic [23:0] EPSILON_RST       = 24'd1;

  // pipeline control handed to the pipelined arithmetic units
  typedef struct packed {
    logic en;
    logic valid;
  } stage_ctrl_t;

endpackage

`default_nettype wire

// ===== src/owu_if.sv =====
// ----------------------------------------------------------------------------
// owu_if
// Request channels of the optimizer weight update block: input items,
// result items and configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface owu_in_if import owu_pkg::*; #(
  parameter int DW = DATA_WIDTH_DEF
);
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] gradient;
  logic signed [DW-1:0] weight;
  logic        [DW-1:0] square_acc;
  logic signed [DW-1:0] momentum;
  logic                 is_last_in;

  modport source (output valid, gradient, weight, square_acc, momentum, is_last_in,
                  input ready);
  modport sink   (input valid, gradient, weight, square_acc, momentum, is_last_in,
                  output ready);
endinterface

interface owu_out_if import owu_pkg::*; #(
  parameter int DW = DATA_WIDTH_DEF
);
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] new_weight;
  logic        [DW-1:0] new_square_acc;
  logic signed [DW-1:0] new_momentum;
  logic                 is_last_out;

  modport source (output valid, new_weight, new_square_acc, new_momentum, is_last_out,
                  input ready);
  modport sink   (input valid, new_weight, new_square_acc, new_momentum, is_last_out,
                  output ready);
endinterface

interface owu_cfg_if import owu_pkg::*; #(
  parameter int CW = FRAC_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CW-1:0]        data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/owu_sqrt.sv =====
// ----------------------------------------------------------------------------
// owu_sqrt
// Pipelined floor square root, one root bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module owu_sqrt import owu_pkg::*; #(
  parameter int  IN_W = 56,
  parameter int  SB_W = 1,
  localparam int RW   = (IN_W + 1) / 2
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire stage_ctrl_t       ctrl_i,
  input  wire logic [IN_W-1:0]   rad_i,
  input  wire logic [SB_W-1:0]   sb_i,
  output logic                   valid_o,
  output logic [RW-1:0]          root_o,
  output logic [SB_W-1:0]        sb_o
);

  localparam int XE = 2 * RW;

  logic [XE-1:0]   x_q    [RW];
  logic [RW+1:0]   rem_q  [RW];
  logic [RW-1:0]   root_q [RW];
  logic            vld_q  [RW];
  logic [SB_W-1:0] sb_q   [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [XE-1:0]   x_in;
    logic [RW+1:0]   rem_in;
    logic [RW-1:0]   root_in;
    logic            vld_in;
    logic [SB_W-1:0] sb_in;
    logic [RW+1:0]   rem_sh;
    logic [RW+1:0]   trial;
    logic            ge;

    if (k == 0) begin : g_first
      assign x_in    = XE'(rad_i);
      assign rem_in  = '0;
      assign root_in = '0;
      assign vld_in  = ctrl_i.valid;
      assign sb_in   = sb_i;
    end else begin : g_next
      assign x_in    = x_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign vld_in  = vld_q[k-1];
      assign sb_in   = sb_q[k-1];
    end

    // bring down the next two radicand bits, try root*4+1
    assign rem_sh = {rem_in[RW-1:0], x_in[XE-1 -: 2]};
    assign trial  = {root_in, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (ctrl_i.en) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctrl_i.en) begin
        x_q[k]    <= x_in << 2;
        rem_q[k]  <= ge ? (rem_sh - trial) : rem_sh;
        root_q[k] <= {root_in[RW-2:0], ge};
        sb_q[k]   <= sb_in;
      end
    end
  end

  assign valid_o = vld_q[RW-1];
  assign root_o  = root_q[RW-1];
  assign sb_o    = sb_q[RW-1];

endmodule

`default_nettype wire

// ===== src/owu_div.sv =====
// ----------------------------------------------------------------------------
// owu_div
// Pipelined restoring divider of (mag << FB) by den, one quotient bit per
// register stage. A zero divisor yields a meaningless quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module owu_div import owu_pkg::*; #(
  parameter int  MAG_W = 32,
  parameter int  DEN_W = 32,
  parameter int  FB    = 24,
  parameter int  SB_W  = 1,
  localparam int NW    = MAG_W + FB
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire stage_ctrl_t       ctrl_i,
  input  wire logic [MAG_W-1:0]  mag_i,
  input  wire logic [DEN_W-1:0]  den_i,
  input  wire logic [SB_W-1:0]   sb_i,
  output logic                   valid_o,
  output logic [NW-1:0]          quo_o,
  output logic [SB_W-1:0]        sb_o
);

  // dividend bits shift out at the top while quotient bits shift in below
  logic [NW-1:0]    nq_q  [NW];
  logic [DEN_W-1:0] rem_q [NW];
  logic [DEN_W-1:0] den_q [NW];
  logic             vld_q [NW];
  logic [SB_W-1:0]  sb_q  [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [NW-1:0]    nq_in;
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic             vld_in;
    logic [SB_W-1:0]  sb_in;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_nx;
    logic             ge;

    if (k == 0) begin : g_first
      assign nq_in  = {mag_i, {FB{1'b0}}};
      assign rem_in = '0;
      assign den_in = den_i;
      assign vld_in = ctrl_i.valid;
      assign sb_in  = sb_i;
    end else begin : g_next
      assign nq_in  = nq_q[k-1];
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign vld_in = vld_q[k-1];
      assign sb_in  = sb_q[k-1];
    end

    assign rem_sh = {rem_in, nq_in[NW-1]};
    assign ge     = (rem_sh >= {1'b0, den_in});
    assign rem_nx = ge ? (rem_sh - {1'b0, den_in}) : rem_sh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (ctrl_i.en) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctrl_i.en) begin
        nq_q[k]  <= {nq_in[NW-2:0], ge};
        rem_q[k] <= rem_nx[DEN_W-1:0];
        den_q[k] <= den_in;
        sb_q[k]  <= sb_in;
      end
    end
  end

  assign valid_o = vld_q[NW-1];
  assign quo_o   = nq_q[NW-1];
  assign sb_o    = sb_q[NW-1];

endmodule

`default_nettype wire

// ===== src/optimizer_weight_update.sv =====
// ----------------------------------------------------------------------------
// optimizer_weight_update
// Per-element SGD / momentum / Adagrad / RMSprop / Adam update in fixed point.
// ----------------------------------------------------------------------------
// One element (Q8.24 by default) is accepted every cycle while the output is not
// stalled, and results leave in order, one per element. The path runs through
// five stages of multiply / saturate, one stage per root bit of the square root
// pipeline, one stage per quotient bit of the divider, then denominator,
// quotient-saturation and output stages. A stall on the output freezes the
// whole pipeline; nothing is dropped. Configuration writes are always taken
// and must only be issued while no element is in flight.
`default_nettype none

module optimizer_weight_update import owu_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  owu_cfg_if.sink    cfg_s,
  owu_in_if.sink     in_s,
  owu_out_if.source  out_m
);

  localparam int DW    = DATA_WIDTH;
  localparam int FB    = FRAC_BITS;
  localparam int CW    = FRAC_BITS;
  localparam int XW    = 2 * DW + CW + 2;
  localparam int PW    = DW + CW + 1;
  localparam int RADW  = DW + FB;
  localparam int RW    = (RADW + 1) / 2;
  localparam int DENW  = (RW > DW) ? RW : DW;
  localparam int NW    = DW + FB;
  localparam int SBQ_W = 4 * DW + 1;
  localparam int SBD_W = 3 * DW + 4;

  localparam logic signed [XW-1:0] SMAX_X = XW'({1'b0, {(DW-1){1'b1}}});
  localparam logic signed [XW-1:0] SMIN_X = -SMAX_X - 1;
  localparam logic signed [XW-1:0] UMAX_X = XW'({DW{1'b1}});
  localparam logic [DW-1:0]        SMIN_MAG = {1'b1, {(DW-1){1'b0}}};
  localparam logic [CW:0]          ONE    = {1'b1, {CW{1'b0}}};

  function automatic logic [DW-1:0] sat_s(input logic signed [XW-1:0] v);
    if (v > SMAX_X) return SMAX_X[DW-1:0];
    if (v < SMIN_X) return SMIN_X[DW-1:0];
    return v[DW-1:0];
  endfunction

  function automatic logic [DW-1:0] sat_u(input logic signed [XW-1:0] v);
    if (v > UMAX_X) return UMAX_X[DW-1:0];
    if (v < 0) return '0;
    return v[DW-1:0];
  endfunction

  // ---------------- configuration ----------------
  logic [MODE_W-1:0] mode_q;
  logic [CW-1:0]     lr_q, wd_q, mu_q, beta_q, eps_q;
  logic [CW:0]       omu, obeta;

  assign cfg_s.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_SGD;
      lr_q   <= CW'(LEARNING_RATE_RST);
      wd_q   <= CW'(WEIGHT_DECAY_RST);
      mu_q   <= CW'(MOMENTUM_COEF_RST);
      beta_q <= CW'(SQUARE_COEF_RST);
      eps_q  <= CW'(EPSILON_RST);
    end else if (cfg_s.valid) begin
      case (cfg_s.index)
        REG_MODE:          mode_q <= cfg_s.data[MODE_W-1:0];
        REG_LEARNING_RATE: lr_q   <= cfg_s.data;
        REG_WEIGHT_DECAY:  wd_q   <= cfg_s.data;
        REG_MOMENTUM_COEF: mu_q   <= cfg_s.data;
        REG_SQUARE_COEF:   beta_q <= cfg_s.data;
        REG_EPSILON:       eps_q  <= cfg_s.data;
        default: ;
      endcase
    end
  end

  assign omu   = ONE - {1'b0, mu_q};
  assign obeta = ONE - {1'b0, beta_q};

  // ---------------- pipeline control ----------------
  logic en;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, sd_v_q, qs_v_q, ov_q;
  logic sq_valid, dv_valid;

  assign en          = !ov_q || out_m.ready;
  assign in_s.ready  = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      v5_q   <= 1'b0;
      sd_v_q <= 1'b0;
      qs_v_q <= 1'b0;
      ov_q   <= 1'b0;
    end else if (en) begin
      v1_q   <= in_s.valid;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      v4_q   <= v3_q;
      v5_q   <= v4_q;
      sd_v_q <= sq_valid;
      qs_v_q <= dv_valid;
      ov_q   <= qs_v_q;
    end
  end

  // ---------------- stage 1: raw products ----------------
  logic signed [DW-1:0]   g1_q, w1_q, m1_q;
  logic        [DW-1:0]   s1_q;
  logic                   last1_q;
  logic signed [PW-1:0]   p_wl1_q, p_mm1_q;
  logic signed [2*DW-1:0] p_gg1_q;
  logic        [DW+CW-1:0] p_sm1_q, p_sb1_q;
  logic        [2*CW:0]   p_ca1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      g1_q    <= in_s.gradient;
      w1_q    <= in_s.weight;
      s1_q    <= in_s.square_acc;
      m1_q    <= in_s.momentum;
      last1_q <= in_s.is_last_in;
      p_wl1_q <= in_s.weight * $signed({1'b0, wd_q});
      p_gg1_q <= in_s.gradient * in_s.gradient;
      p_mm1_q <= in_s.momentum * $signed({1'b0, mu_q});
      p_sm1_q <= in_s.square_acc * mu_q;
      p_sb1_q <= in_s.square_acc * beta_q;
      p_ca1_q <= omu * lr_q;
    end
  end

  // ---------------- stage 2: scale, d and q ----------------
  logic signed [PW-1:0]   wl_sh, mm_sh;
  logic signed [2*DW-1:0] gg_sh;
  logic signed [XW-1:0]   d_x;

  assign wl_sh = p_wl1_q >>> FB;
  assign mm_sh = p_mm1_q >>> FB;
  assign gg_sh = p_gg1_q >>> FB;
  assign d_x   = XW'(g1_q) + XW'(wl_sh);

  logic signed [DW-1:0] d2_q, mm2_q, w2_q, m2_q;
  logic        [DW-1:0] q2_q, sm2_q, sb2_q, s2_q;
  logic        [CW-1:0] ca2_q;
  logic                 last2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      d2_q    <= sat_s(d_x);
      q2_q    <= sat_u(XW'(gg_sh));
      mm2_q   <= mm_sh[DW-1:0];           // |mu*m| < |m|
      sm2_q   <= p_sm1_q[DW+FB-1:FB];
      sb2_q   <= p_sb1_q[DW+FB-1:FB];
      ca2_q   <= p_ca1_q[2*CW-1:FB];      // (1-mu)*alpha <= alpha
      w2_q    <= w1_q;
      s2_q    <= s1_q;
      m2_q    <= m1_q;
      last2_q <= last1_q;
    end
  end

  // ---------------- stage 3: step products ----------------
  logic signed [PW-1:0] step_p3_q, adam_p3_q;
  logic        [PW-1:0] qmu_p3_q, qb_p3_q;
  logic        [DW-1:0] q3_q, sm3_q, sb3_q, s3_q;
  logic signed [DW-1:0] mm3_q, w3_q, m3_q;
  logic                 last3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      step_p3_q <= $signed({1'b0, lr_q}) * d2_q;
      adam_p3_q <= $signed({1'b0, ca2_q}) * d2_q;
      qmu_p3_q  <= omu * q2_q;
      qb_p3_q   <= obeta * q2_q;
      q3_q      <= q2_q;
      sm3_q     <= sm2_q;
      sb3_q     <= sb2_q;
      s3_q      <= s2_q;
      mm3_q     <= mm2_q;
      w3_q      <= w2_q;
      m3_q      <= m2_q;
      last3_q   <= last2_q;
    end
  end

  // ---------------- stage 4: new momentum and accumulator ----------------
  logic signed [PW-1:0] step_sh, adam_sh;
  logic signed [DW-1:0] step_c, adamt_c, m4_d;
  logic        [DW-1:0] qm_c, qb_c, s4_d;

  assign step_sh = step_p3_q >>> FB;
  assign adam_sh = adam_p3_q >>> FB;
  assign step_c  = step_sh[DW-1:0];       // coefficient below one keeps it in range
  assign adamt_c = adam_sh[DW-1:0];
  assign qm_c    = qmu_p3_q[DW+FB-1:FB];
  assign qb_c    = qb_p3_q[DW+FB-1:FB];

  always_comb begin
    m4_d = m3_q;
    s4_d = s3_q;
    case (mode_q)
      MODE_MOMENTUM: m4_d = sat_s(XW'(mm3_q) - XW'(step_c));
      MODE_ADAGRAD:  s4_d = sat_u(XW'(s3_q) + XW'(q3_q));
      MODE_RMSPROP:  s4_d = sat_u(XW'(sm3_q) + XW'(qm_c));
      MODE_ADAM: begin
        m4_d = sat_s(XW'(mm3_q) - XW'(adamt_c));
        s4_d = sat_u(XW'(sb3_q) + XW'(qb_c));
      end
      default: ;
    endcase
  end

  logic signed [DW-1:0] step4_q, m4_q, w4_q;
  logic        [DW-1:0] s4_q;
  logic                 last4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      step4_q <= step_c;
      m4_q    <= m4_d;
      s4_q    <= s4_d;
      w4_q    <= w3_q;
      last4_q <= last3_q;
    end
  end

  // ---------------- stage 5: radicand, numerator, simple weights ----------------
  logic        [DW-1:0] rad5_d;
  logic signed [DW-1:0] num5_d, w5_d;

  always_comb begin
    rad5_d = sat_u(XW'(s4_q) + XW'(eps_q));
    num5_d = step4_q;
    w5_d   = w4_q;
    case (mode_q)
      MODE_SGD:      w5_d = sat_s(XW'(w4_q) - XW'(step4_q));
      MODE_MOMENTUM: w5_d = sat_s(XW'(w4_q) + XW'(m4_q));
      MODE_ADAGRAD:  rad5_d = s4_q;        // eps goes after the root here
      MODE_ADAM:     num5_d = m4_q;
      default: ;
    endcase
  end

  logic        [DW-1:0] rad5_q, s5_q;
  logic signed [DW-1:0] num5_q, w5_q, m5_q;
  logic                 last5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad5_q  <= rad5_d;
      num5_q  <= num5_d;
      w5_q    <= w5_d;
      s5_q    <= s4_q;
      m5_q    <= m4_q;
      last5_q <= last4_q;
    end
  end

  // ---------------- square root ----------------
  logic [RW-1:0]        sq_root;
  logic [SBQ_W-1:0]     sq_sb;
  logic signed [DW-1:0] sq_w, sq_m, sq_num;
  logic        [DW-1:0] sq_s;
  logic                 sq_last;

  owu_sqrt #(
    .IN_W (RADW),
    .SB_W (SBQ_W)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  ('{en: en, valid: v5_q}),
    .rad_i   ({rad5_q, {FB{1'b0}}}),
    .sb_i    ({w5_q, s5_q, m5_q, num5_q, last5_q}),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .sb_o    (sq_sb)
  );

  assign {sq_w, sq_s, sq_m, sq_num, sq_last} = sq_sb;

  // ---------------- denominator stage ----------------
  logic [DENW:0]   dsum;
  logic [DENW-1:0] den_d;
  logic [DW-1:0]   mag_d;

  assign dsum  = (DENW+1)'(sq_root) + (DENW+1)'(eps_q);
  assign mag_d = sq_num[DW-1] ? (~sq_num + 1'b1) : sq_num;

  always_comb begin
    den_d = DENW'(sq_root);
    if (mode_q == MODE_ADAGRAD) begin
      den_d = (dsum > (DENW+1)'({DW{1'b1}})) ? DENW'({DW{1'b1}}) : dsum[DENW-1:0];
    end
  end

  logic [DENW-1:0]      sd_den_q;
  logic [DW-1:0]        sd_mag_q, sd_s_q;
  logic signed [DW-1:0] sd_w_q, sd_m_q;
  logic                 sd_neg_q, sd_nzero_q, sd_dz_q, sd_last_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd_den_q   <= den_d;
      sd_mag_q   <= mag_d;
      sd_neg_q   <= sq_num[DW-1];
      sd_nzero_q <= (sq_num == '0);
      sd_dz_q    <= (den_d == '0);
      sd_w_q     <= sq_w;
      sd_s_q     <= sq_s;
      sd_m_q     <= sq_m;
      sd_last_q  <= sq_last;
    end
  end

  // ---------------- divider ----------------
  logic [NW-1:0]        dv_quo;
  logic [SBD_W-1:0]     dv_sb;
  logic signed [DW-1:0] dv_w, dv_m;
  logic        [DW-1:0] dv_s;
  logic                 dv_neg, dv_nzero, dv_dz, dv_last;

  owu_div #(
    .MAG_W (DW),
    .DEN_W (DENW),
    .FB    (FB),
    .SB_W  (SBD_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  ('{en: en, valid: sd_v_q}),
    .mag_i   (sd_mag_q),
    .den_i   (sd_den_q),
    .sb_i    ({sd_w_q, sd_s_q, sd_m_q, sd_neg_q, sd_nzero_q, sd_dz_q, sd_last_q}),
    .valid_o (dv_valid),
    .quo_o   (dv_quo),
    .sb_o    (dv_sb)
  );

  assign {dv_w, dv_s, dv_m, dv_neg, dv_nzero, dv_dz, dv_last} = dv_sb;

  // ---------------- quotient saturation ----------------
  logic signed [DW-1:0] quot_d;

  always_comb begin
    if (dv_dz) begin
      // zero denominator: saturate toward the numerator's sign, zero for a zero numerator
      quot_d = dv_nzero ? '0 : (dv_neg ? SMIN_X[DW-1:0] : SMAX_X[DW-1:0]);
    end else if (!dv_neg) begin
      quot_d = (dv_quo > NW'(SMAX_X[DW-1:0])) ? SMAX_X[DW-1:0] : dv_quo[DW-1:0];
    end else begin
      quot_d = (dv_quo > NW'(SMIN_MAG)) ? SMIN_X[DW-1:0] : (~dv_quo[DW-1:0] + 1'b1);
    end
  end

  logic signed [DW-1:0] qs_quot_q, qs_w_q, qs_m_q;
  logic        [DW-1:0] qs_s_q;
  logic                 qs_last_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      qs_quot_q <= quot_d;
      qs_w_q    <= dv_w;
      qs_s_q    <= dv_s;
      qs_m_q    <= dv_m;
      qs_last_q <= dv_last;
    end
  end

  // ---------------- output stage ----------------
  logic signed [DW-1:0] wout_d;

  always_comb begin
    case (mode_q)
      MODE_ADAGRAD, MODE_RMSPROP: wout_d = sat_s(XW'(qs_w_q) - XW'(qs_quot_q));
      MODE_ADAM:                  wout_d = sat_s(XW'(qs_w_q) + XW'(qs_quot_q));
      default:                    wout_d = qs_w_q;
    endcase
  end

  logic signed [DW-1:0] out_w_q, out_m_q;
  logic        [DW-1:0] out_s_q;
  logic                 out_last_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_w_q    <= wout_d;
      out_s_q    <= qs_s_q;
      out_m_q    <= qs_m_q;
      out_last_q <= qs_last_q;
    end
  end

  assign out_m.valid          = ov_q;
  assign out_m.new_weight     = out_w_q;
  assign out_m.new_square_acc = out_s_q;
  assign out_m.new_momentum   = out_m_q;
  assign out_m.is_last_out    = out_last_q;

  // ---------------- assertions ----------------
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_s.valid && in_s.ready) |=> v1_q)
    else $error("accepted request did not enter stage 1");

  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(v5_q) && $stable(sd_v_q) && $stable(qs_v_q)))
    else $error("pipeline moved during output stall");

  a_div_to_qs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en |=> (qs_v_q == $past(dv_valid)))
    else $error("divider result lost on its way to saturation stage");

endmodule

`default_nettype wire
